[hw/rtl/cnt_pkg.sv]
`default_nettype none
package cnt_pkg;

  localparam int unsigned MapBytes = 65536;
  localparam int unsigned Words    = MapBytes / 8;
  localparam int unsigned AddrW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned CountW   = 17;
  localparam int unsigned CountMax = (1 << CountW) - 1;
  localparam int unsigned CountCap = (MapBytes < CountMax) ? MapBytes : CountMax;

  localparam int unsigned IndexW   = 13;
  localparam int unsigned RawW     = 64;
  localparam int unsigned PosW     = 16;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 48;

  localparam logic KindEntry   = 1'b0;
  localparam logic KindVerdict = 1'b1;

  localparam logic [1:0] VerdictNone  = 2'd0;
  localparam logic [1:0] VerdictHits  = 2'd1;
  localparam logic [1:0] VerdictBytes = 2'd2;

  function automatic logic [7:0] bucket(input logic [7:0] c);
    logic [7:0] r;
    if (c <= 8'd2) begin
      r = c;
    end else if (c == 8'd3) begin
      r = 8'd4;
    end else if (c < 8'd8) begin
      r = 8'd8;
    end else if (c < 8'd16) begin
      r = 8'd16;
    end else if (c < 8'd32) begin
      r = 8'd32;
    end else if (c < 8'd128) begin
      r = 8'd64;
    end else begin
      r = 8'd128;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/cnt_ram.sv]
`default_nettype none
module cnt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                                        clk_i,
  input  wire                                        we_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire [WIDTH-1:0]                            wdata_i,
  input  wire                                        re_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/coverage_novelty_tracker.sv]
// Each accepted word is read from the virgin store, then evaluated and written back, then
// one result is registered per overlapping byte entry and, at end of scan, one for the
//   verdict; output stalls hold these results, and no new word is taken until they are registered.
// Reset: verdict and entry count clear at once; a clearing pass then sets all
//   8192 virgin words to ones, one word a cycle, with s_axis_tready held low.
`default_nettype none
module coverage_novelty_tracker
  import cnt_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire [InDataW-1:0]   s_axis_tdata,   // word_index[12:0], raw_counts[76:13], zero pad
  input  wire                 s_axis_tlast,   // end_of_scan
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // byte_position[15:0], overlap_value[23:16],
                                              // verdict[25:24], entry_count[42:26], zero pad
  output logic                m_axis_tuser,   // kind
  output logic                m_axis_tlast    // last
);

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StLook  = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [IndexW-1:0] idx_q;
  logic [RawW-1:0]   raw_q;
  logic              eos_q;
  logic              range_q;
  logic [7:0]        pend_q, pend_d;
  logic [RawW-1:0]   ov_q;
  logic [1:0]        verdict_q, verdict_d;
  logic [CountW-1:0] count_q, count_d;

  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic                m_user_q, m_user_d;
  logic                m_last_q, m_last_d;

  logic              accept;
  logic [RawW-1:0]   vir;
  logic [RawW-1:0]   cls;
  logic [RawW-1:0]   ov;
  logic [7:0]        ov_mask;
  logic              pristine;
  logic              hit;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [RawW-1:0]   ram_wdata;
  logic              out_free;
  logic [2:0]        sel;
  logic [7:0]        pend_next;
  logic [PosW-1:0]   pos;

  function automatic logic [2:0] lowest(input logic [7:0] m);
    logic [2:0] r;
    r = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (m[k]) begin
        r = 3'(k);
      end
    end
    return r;
  endfunction

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  cnt_ram #(
    .WIDTH (RawW),
    .DEPTH (Words)
  ) u_virgin (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (AddrW'(s_axis_tdata[IndexW-1:0])),
    .rdata_o (vir)
  );

  always_comb begin
    pristine = 1'b0;
    for (int j = 0; j < 8; j++) begin
      cls[8*j +: 8] = bucket(raw_q[8*j +: 8]);
      ov[8*j +: 8]  = cls[8*j +: 8] & vir[8*j +: 8];
      ov_mask[j]    = (ov[8*j +: 8] != 8'h00);
      if ((cls[8*j +: 8] != 8'h00) && (vir[8*j +: 8] == 8'hff)) begin
        pristine = 1'b1;
      end
    end
    hit = range_q && (ov_mask != 8'h00);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AddrW'(idx_q);
    ram_wdata = vir & ~cls;
    if (state_q == StClear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '1;
    end else if (state_q == StLook) begin
      ram_we = hit;
    end
  end

  assign sel       = lowest(pend_q);
  assign pend_next = pend_q & ~(8'h01 << sel);
  assign pos       = PosW'({idx_q, sel});

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    pend_d    = pend_q;
    verdict_d = verdict_q;
    count_d   = count_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      StClear: begin
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Words - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          state_d = StLook;
        end
      end
      StLook: begin
        pend_d = hit ? ov_mask : 8'h00;
        if (hit && (verdict_q < VerdictBytes)) begin
          verdict_d = pristine ? VerdictBytes : VerdictHits;
        end
        state_d = (hit || eos_q) ? StEmit : StIdle;
      end
      StEmit: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          if (pend_q != 8'h00) begin
            m_user_d = KindEntry;
            m_data_d = OutDataW'({2'b00, ov_q[{sel, 3'b000} +: 8], pos});
            m_last_d = (pend_next == 8'h00) && !eos_q;
            pend_d   = pend_next;
            if (32'(count_q) < CountCap) begin
              count_d = count_q + CountW'(1);
            end
            if ((pend_next == 8'h00) && !eos_q) begin
              state_d = StIdle;
            end
          end else begin
            m_user_d  = KindVerdict;
            m_data_d  = OutDataW'({count_q, verdict_q, 8'h00, PosW'(0)});
            m_last_d  = 1'b1;
            verdict_d = VerdictNone;
            count_d   = '0;
            state_d   = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      pend_q    <= '0;
      verdict_q <= VerdictNone;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      pend_q    <= pend_d;
      verdict_q <= verdict_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q   <= s_axis_tdata[IndexW-1:0];
      raw_q   <= s_axis_tdata[IndexW +: RawW];
      eos_q   <= s_axis_tlast;
      range_q <= (32'(s_axis_tdata[IndexW-1:0]) < Words);
    end
    if (state_q == StLook) begin
      ov_q <= ov;
    end
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule
`default_nettype wire

[tb/tb_top.sv]
module tb_top;
  import cnt_pkg::*;

  localparam int unsigned Limit       = 1500000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned HoldAfter   = 60;
  localparam int unsigned RandomWords = 113;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned PadW        = InDataW - RawW - IndexW;

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [RawW-1:0]   raw;
    logic              eos;
  } map_word_t;

  typedef struct packed {
    logic              kind;
    logic [PosW-1:0]   pos;
    logic [7:0]        overlap;
    logic [1:0]        verdict;
    logic [CountW-1:0] count;
    logic              last;
  } result_t;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_data  = '0;
  logic                s_last  = 1'b0;
  logic                m_ready = 1'b0;
  wire                 s_ready;
  wire                 m_valid;
  wire [OutDataW-1:0]  m_data;
  wire                 m_user;
  wire                 m_last;

  map_word_t           map_words [$];
  result_t             due_results [$];
  logic [RawW-1:0]     virgin_words [Words];
  logic [1:0]          scan_verdict = VerdictNone;
  logic [CountW-1:0]   entry_tally  = '0;

  logic                word_taken     = 1'b0;
  int unsigned         words_accepted = 0;
  int unsigned         error_count    = 0;
  int unsigned         cycle_count    = 0;
  int unsigned         burst_left     = 0;
  int unsigned         gap_left       = 0;
  int unsigned         rx_run         = 0;
  int unsigned         rx_stall       = 0;
  int unsigned         hold_left      = 0;
  logic                hold_done      = 1'b0;

  coverage_novelty_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] hit_class(input logic [7:0] c);
    casez (c)
      8'b1???????: return 8'h80;
      8'b01??????: return 8'h40;
      8'b001?????: return 8'h40;
      8'b0001????: return 8'h20;
      8'b00001???: return 8'h10;
      8'b000001??: return 8'h08;
      8'b00000011: return 8'h04;
      default:     return c;
    endcase
  endfunction

  function automatic logic [7:0] count_in_class(input int unsigned k);
    logic [7:0] r;
    case (k)
      0:       r = 8'd0;
      1:       r = 8'd1;
      2:       r = 8'd2;
      3:       r = 8'd3;
      4:       r = 8'($urandom_range(4, 7));
      5:       r = 8'($urandom_range(8, 15));
      6:       r = 8'($urandom_range(16, 31));
      7:       r = 8'($urandom_range(32, 127));
      default: r = 8'($urandom_range(128, 255));
    endcase
    return r;
  endfunction

  function automatic logic [7:0] random_count();
    int unsigned sel;
    sel = $urandom_range(0, 11);
    if (sel < 3) return 8'd0;
    if (sel < 5) return 8'($urandom_range(0, 255));
    return count_in_class($urandom_range(1, 8));
  endfunction

  function automatic void push_word(input logic [IndexW-1:0] index,
                                    input logic [RawW-1:0] raw, input logic eos);
    map_word_t w;
    w.index = index;
    w.raw   = raw;
    w.eos   = eos;
    map_words.push_back(w);
  endfunction

  // update virgin bits, verdict and tally; queue the results this word causes
  task automatic score_word(input map_word_t w);
    result_t     found [9];
    int unsigned n;
    logic [63:0] old_bits;
    logic [63:0] cls;
    logic [7:0]  c;
    logic [7:0]  v;
    logic        fresh;
    n = 0;
    cls = '0;
    fresh = 1'b0;
    if (w.index < Words) begin
      old_bits = virgin_words[w.index];
      for (int j = 0; j < 8; j++) begin
        c = hit_class(w.raw[8*j +: 8]);
        v = old_bits[8*j +: 8];
        cls[8*j +: 8] = c;
        if ((c & v) != 8'd0) begin
          found[n] = '{KindEntry, {w.index, 3'(j)}, c & v, VerdictNone, '0, 1'b0};
          n++;
          if (entry_tally < CountCap) entry_tally++;
        end
        if (c != 8'd0 && v == 8'hff) fresh = 1'b1;
      end
      if ((cls & old_bits) != '0) begin
        if (scan_verdict < VerdictBytes) scan_verdict = fresh ? VerdictBytes : VerdictHits;
        virgin_words[w.index] = old_bits & ~cls;
      end
    end
    if (w.eos) begin
      found[n] = '{KindVerdict, '0, 8'd0, scan_verdict, entry_tally, 1'b0};
      n++;
      scan_verdict = VerdictNone;
      entry_tally = '0;
    end
    for (int k = 0; k < n; k++) begin
      found[k].last = (k == n - 1);
      due_results.push_back(found[k]);
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      word_taken <= s_valid && s_ready;
      if (s_valid && s_ready) begin
        score_word(map_words.pop_front());
        words_accepted <= words_accepted + 1;
      end
      if (m_valid && m_ready) begin
        got = '{m_user, m_data[15:0], m_data[23:16], m_data[25:24], m_data[42:26], m_last};
        if (due_results.size() == 0) begin
          error_count++;
          if (error_count <= ReportMax)
            $display("unexpected result word: kind %0d pos %0d overlap %02h verdict %0d",
                     got.kind, got.pos, got.overlap, got.verdict,
                     " count %0d last %0d", got.count, got.last);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= ReportMax) begin
              $display("result mismatch: expected kind %0d pos %0d overlap %02h verdict %0d",
                       want.kind, want.pos, want.overlap, want.verdict,
                       " count %0d last %0d", want.count, want.last);
              $display("                 actual   kind %0d pos %0d overlap %02h verdict %0d",
                       got.kind, got.pos, got.overlap, got.verdict,
                       " count %0d last %0d", got.count, got.last);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == Limit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // offer words in bursts; hold the current word until taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_valid || word_taken)) begin
      if (gap_left != 0 || map_words.size() == 0) begin
        s_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        s_valid <= 1'b1;
        s_data  <= {{PadW{1'b0}}, map_words[0].raw, map_words[0].index};
        s_last  <= map_words[0].eos;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_ready   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_accepted >= HoldAfter) begin
      m_ready   <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (rx_stall != 0) begin
      m_ready  <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (rx_run != 0) begin
      m_ready <= 1'b1;
      rx_run  <= rx_run - 1;
    end else begin
      m_ready  <= 1'b1;
      rx_run   <= $urandom_range(0, 12);
      rx_stall <= $urandom_range(0, 3);
    end
  end

  initial begin
    map_word_t       w;
    for (int i = 0; i < Words; i++) virgin_words[i] = '1;

    push_word(13'd0, 64'h0, 1'b0);
    push_word(13'd0, 64'h8020_1008_0403_0201, 1'b0);
    push_word(13'd0, 64'h8020_1008_0403_0201, 1'b0);
    push_word(13'd0, 64'h0906_05ff_7f1f_0f07, 1'b0);
    push_word(13'd8191, '1, 1'b0);
    push_word(13'd8191, '1, 1'b1);
    push_word(13'd5, 64'h0, 1'b1);
    push_word(13'd0, 64'h40, 1'b1);
    push_word(13'd0, 64'h4000, 1'b0);
    push_word(13'd2, 64'h01, 1'b0);
    push_word(13'd0, 64'h40, 1'b0);
    push_word(13'h1555, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    push_word(13'd0, 64'h40_0000, 1'b0);
    push_word(13'd0, 64'h80_0000, 1'b1);
    push_word(13'h0aaa, 64'h5555_5555_5555_5555, 1'b0);
    push_word(13'd4096, 64'h0003_0000_0000_0300, 1'b0);
    push_word(13'd3, 64'h0, 1'b0);

    for (int i = 0; i < RandomWords; i++) begin
      w.index = ($urandom_range(0, 9) < 7) ? 13'($urandom_range(0, 31)) : 13'($urandom);
      for (int j = 0; j < 8; j++) w.raw[8*j +: 8] = random_count();
      w.eos = (i == RandomWords - 1) || ($urandom_range(0, 9) == 0);
      map_words.push_back(w);
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (map_words.size() != 0 || due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
